>>> hw/rtl/iosiq_pkg.sv
// shared types, codes and constants of the sync-point increment queue
package iosiq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int HANDLE_W        = 32;
    localparam int POINT_W         = 8;
    localparam int FUNC_W          = 2;
    localparam int KIND_W          = 2;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_IMM   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEFER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DONE  = 2'd2;

    // result codes
    localparam logic [KIND_W-1:0] KIND_HANDLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUMP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

    // request transaction
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [POINT_W-1:0]  sync_point;
        logic [HANDLE_W-1:0] done_handle;
    } cmd_item_t;

    // result transaction
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] issued_handle;
        logic [POINT_W-1:0]  bump_point;
        logic                last;
    } rsp_item_t;

    // one queue entry as kept in the entry memory
    typedef struct packed {
        logic                complete;
        logic [HANDLE_W-1:0] handle;
        logic [POINT_W-1:0]  point;
    } entry_t;

    // what the result register is loaded with
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_FULL,
        EMIT_HANDLE,
        EMIT_PEND_MID,
        EMIT_PEND_LAST
    } emit_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic      latch;
        logic      append;
        emit_sel_t emit;
        logic      scan_clr;
        logic      rd_scan;
        logic      rd_head;
        logic      scan_inc;
        logic      mark;
        logic      pop;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              occ_zero;
        logic              scan_end;
        logic              hit;
        logic              head_done;
        logic              out_free;
    } sts_t;

endpackage

>>> hw/rtl/in_order_syncpoint_increment_queue.sv
// top level of the in-order sync-point increment queue
// An ordered ring of up to QUEUE_DEPTH sync-point increments that take effect in
// issue order. One request transaction is taken at a time: cmd_stall is low only
// while the block is idle. A request with nothing to search or retire passes
// through acceptance and dispatch. A done signal adds the head-to-tail handle
// search, one memory read and one compare for each entry probed, up to the first
// match or the tail. After an immediate increment or a done signal, complete
// entries are retired from the head until the queue runs empty or stops at a
// pending entry. A new result waits while the result register is not taken.
// The entry memory is read at one address a cycle, with registered data.
// Results leave through a result register, so a request is taken while the last
// result still waits.
module in_order_syncpoint_increment_queue import iosiq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    ctl_t ctl;
    sts_t st;

    // sequencing
    iosiq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .st        (st),
        .ctl       (ctl)
    );

    // storage and result path
    iosiq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .ctl       (ctl),
        .st        (st)
    );

endmodule

>>> hw/rtl/iosiq_dp.sv
// datapath: entry memory, head and occupancy, handle counter, result register
module iosiq_dp import iosiq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_item_t cmd,
    input  logic      rsp_stall,
    output logic      rsp_valid,
    output rsp_item_t rsp,
    input  ctl_t      ctl,
    output sts_t      st
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);

    entry_t mem [QUEUE_DEPTH];

    cmd_item_t           item_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic [HANDLE_W-1:0] next_handle_reg;
    logic [POINT_W-1:0]  pend_point_reg;
    entry_t              rd_reg;
    logic                rsp_valid_reg;
    rsp_item_t           rsp_reg;

    logic [CNT_W:0]   tail_sum;
    logic [CNT_W:0]   scan_sum;
    logic [IDX_W-1:0] tail_slot;
    logic [IDX_W-1:0] scan_slot;
    logic [IDX_W-1:0] head_next;
    logic             out_free;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // ring slot of an offset from the head, one compare and subtract
    always_comb
    begin
        tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(occ_reg);
        scan_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(scan_reg);
        if (tail_sum >= DEPTH_SUM)
        begin
            tail_sum = tail_sum - DEPTH_SUM;
        end
        if (scan_sum >= DEPTH_SUM)
        begin
            scan_sum = scan_sum - DEPTH_SUM;
        end
        tail_slot = tail_sum[IDX_W-1:0];
        scan_slot = scan_sum[IDX_W-1:0];
        head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    end

    // memory port selection
    always_comb
    begin
        wr_en   = ctl.append | ctl.mark;
        wr_addr = ctl.append ? tail_slot : scan_slot;
        if (ctl.append)
        begin
            wr_data.complete = (item_reg.func == FUNC_IMM);
            wr_data.handle   = (item_reg.func == FUNC_IMM) ? '0 : next_handle_reg;
            wr_data.point    = item_reg.sync_point;
        end
        else
        begin
            wr_data          = rd_reg;
            wr_data.complete = 1'b1;
        end
        rd_en   = ctl.rd_scan | ctl.rd_head;
        rd_addr = ctl.rd_scan ? scan_slot : head_reg;
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            item_reg <= cmd;
        end
        if (ctl.pop)
        begin
            pend_point_reg <= rd_reg.point;
        end
    end

    // queue pointers and handle counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            occ_reg         <= '0;
            scan_reg        <= '0;
            next_handle_reg <= '0;
        end
        else
        begin
            if (ctl.append)
            begin
                occ_reg <= occ_reg + 1'b1;
                if (item_reg.func == FUNC_DEFER)
                begin
                    next_handle_reg <= next_handle_reg + 1'b1;
                end
            end
            else if (ctl.pop)
            begin
                occ_reg  <= occ_reg - 1'b1;
                head_reg <= head_next;
            end
            if (ctl.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (ctl.scan_inc)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.emit != EMIT_NONE)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        case (ctl.emit)
            EMIT_FULL:
            begin
                rsp_reg <= '{kind: KIND_FULL, issued_handle: '0, bump_point: '0,
                             last: 1'b1};
            end
            EMIT_HANDLE:
            begin
                rsp_reg <= '{kind: KIND_HANDLE, issued_handle: next_handle_reg,
                             bump_point: '0, last: 1'b1};
            end
            EMIT_PEND_MID:
            begin
                rsp_reg <= '{kind: KIND_BUMP, issued_handle: '0,
                             bump_point: pend_point_reg, last: 1'b0};
            end
            EMIT_PEND_LAST:
            begin
                rsp_reg <= '{kind: KIND_BUMP, issued_handle: '0,
                             bump_point: pend_point_reg, last: 1'b1};
            end
            default:
            begin
                rsp_reg <= rsp_reg;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // status back to the controller
    always_comb
    begin
        st.func      = item_reg.func;
        st.full      = (occ_reg == DEPTH_CNT);
        st.occ_zero  = (occ_reg == '0);
        st.scan_end  = (scan_reg == occ_reg);
        st.hit       = (rd_reg.handle == item_reg.done_handle);
        st.head_done = rd_reg.complete;
        st.out_free  = out_free;
    end

    // occupancy stays within the ring
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_CNT)
        else $error("occupancy beyond queue depth");

    // no append into a full ring
    a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.append |-> occ_reg != DEPTH_CNT)
        else $error("append while queue full");

    // retirement only from a non-empty ring
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> occ_reg != '0)
        else $error("retire from empty queue");

endmodule

>>> hw/rtl/iosiq_ctrl.sv
// controller: sequences dispatch, handle search and head retirement
module iosiq_ctrl import iosiq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  sts_t st,
    output ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_RETIRE_RD,
        S_RETIRE_CHK,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   have_pend_reg;
    logic   have_pend_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        have_pend_next = have_pend_reg;
        ctl            = '0;
        ctl.emit       = EMIT_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.func == FUNC_IMM || st.func == FUNC_DEFER)
                begin
                    if (st.full)
                    begin
                        if (st.out_free)
                        begin
                            ctl.emit   = EMIT_FULL;
                            state_next = S_IDLE;
                        end
                    end
                    else if (st.func == FUNC_IMM)
                    begin
                        ctl.append = 1'b1;
                        state_next = S_RETIRE_RD;
                    end
                    else if (st.out_free)
                    begin
                        ctl.append = 1'b1;
                        ctl.emit   = EMIT_HANDLE;
                        state_next = S_IDLE;
                    end
                end
                else if (st.func == FUNC_DONE)
                begin
                    ctl.scan_clr = 1'b1;
                    state_next   = S_SEARCH_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            // walk from head to tail for the first matching handle
            S_SEARCH_RD:
            begin
                if (st.scan_end)
                begin
                    state_next = S_RETIRE_RD;
                end
                else
                begin
                    ctl.rd_scan = 1'b1;
                    state_next  = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP:
            begin
                if (st.hit)
                begin
                    ctl.mark   = 1'b1;
                    state_next = S_RETIRE_RD;
                end
                else
                begin
                    ctl.scan_inc = 1'b1;
                    state_next   = S_SEARCH_RD;
                end
            end
            // retire complete entries at the head, the latest one held back for the last flag
            S_RETIRE_RD:
            begin
                if (st.occ_zero)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    ctl.rd_head = 1'b1;
                    state_next  = S_RETIRE_CHK;
                end
            end
            S_RETIRE_CHK:
            begin
                if (!st.head_done)
                begin
                    state_next = S_FLUSH;
                end
                else if (!have_pend_reg || st.out_free)
                begin
                    if (have_pend_reg)
                    begin
                        ctl.emit = EMIT_PEND_MID;
                    end
                    ctl.pop        = 1'b1;
                    have_pend_next = 1'b1;
                    state_next     = S_RETIRE_RD;
                end
            end
            S_FLUSH:
            begin
                if (!have_pend_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    ctl.emit       = EMIT_PEND_LAST;
                    have_pend_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_pend_reg <= have_pend_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

    // a result is only loaded when the result register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit != EMIT_NONE |-> st.out_free)
        else $error("result loaded over an untaken result");

    // every retired entry has been sent by the time a new request is taken
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !have_pend_reg)
        else $error("retired entry left unsent");

endmodule

>>> verif/iosiq_tb_pkg.sv
// predictor and in-order result checker for the sync-point increment queue testbench
package iosiq_tb_pkg;
    import iosiq_pkg::*;

    // keeps its own copy of the ring and checks every result transaction against it
    class increment_tracker_t #(int DEPTH = QUEUE_DEPTH_DEF);
        logic [HANDLE_W-1:0] ring_handle [DEPTH];
        logic [POINT_W-1:0]  ring_point [DEPTH];
        bit                  ring_complete [DEPTH];
        int                  head;
        int                  count;
        logic [HANDLE_W-1:0] handle_ctr;
        rsp_item_t           awaited_results [$];
        int                  errors;
        int                  handles_issued;
        int                  bumps;
        int                  rejects;
        int                  max_batch;

        function new();
            head = 0;
            count = 0;
            handle_ctr = '0;
            errors = 0;
            handles_issued = 0;
            bumps = 0;
            rejects = 0;
            max_batch = 0;
        endfunction

        function void append(logic [HANDLE_W-1:0] h, logic [POINT_W-1:0] p, bit done);
            int s;
            s = (head + count) % DEPTH;
            ring_handle[s] = h;
            ring_point[s] = p;
            ring_complete[s] = done;
            count++;
        endfunction

        // pop completed entries off the head, last flag on the final one
        function void retire_ready();
            rsp_item_t r;
            int        n;
            n = 0;
            while (count > 0 && ring_complete[head])
            begin
                r = '0;
                r.kind = KIND_BUMP;
                r.bump_point = ring_point[head];
                r.last = !(count > 1 && ring_complete[(head + 1) % DEPTH]);
                awaited_results.insert(awaited_results.size(), r);
                head = (head + 1) % DEPTH;
                count--;
                n++;
            end
            if (n > max_batch)
                max_batch = n;
            bumps += n;
        endfunction

        // work out the results of one accepted request transaction
        function void apply_request(cmd_item_t c);
            rsp_item_t r;
            int        i;
            int        s;
            r = '0;
            if (c.func == FUNC_IMM || c.func == FUNC_DEFER)
            begin
                if (count >= DEPTH)
                begin
                    r.kind = KIND_FULL;
                    r.last = 1'b1;
                    awaited_results.insert(awaited_results.size(), r);
                    rejects++;
                end
                else if (c.func == FUNC_IMM)
                begin
                    // immediate entries go in complete, with handle zero
                    append('0, c.sync_point, 1'b1);
                    retire_ready();
                end
                else
                begin
                    r.kind = KIND_HANDLE;
                    r.issued_handle = handle_ctr;
                    r.last = 1'b1;
                    append(handle_ctr, c.sync_point, 1'b0);
                    awaited_results.insert(awaited_results.size(), r);
                    handle_ctr = handle_ctr + 1'b1;
                    handles_issued++;
                end
            end
            else if (c.func == FUNC_DONE)
            begin
                // first match from head to tail only
                for (i = 0; i < count; i++)
                begin
                    s = (head + i) % DEPTH;
                    if (ring_handle[s] == c.done_handle)
                    begin
                        ring_complete[s] = 1'b1;
                        break;
                    end
                end
                retire_ready();
            end
        endfunction

        // handle of a still pending entry: 0 oldest, 1 newest, otherwise any
        function bit pick_pending(int how, output logic [HANDLE_W-1:0] h);
            int slots [$];
            int i;
            int s;
            h = '0;
            for (i = 0; i < count; i++)
            begin
                s = (head + i) % DEPTH;
                if (!ring_complete[s])
                    slots.insert(slots.size(), s);
            end
            if (slots.size() == 0)
                return 1'b0;
            if (how == 0)
                s = slots[0];
            else if (how == 1)
                s = slots[slots.size() - 1];
            else
                s = slots[$urandom_range(0, slots.size() - 1)];
            h = ring_handle[s];
            return 1'b1;
        endfunction

        function void compare_field(realtime stamp, string field,
                                    logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
            if (got !== want)
            begin
                $display("%0.1f ns: %s mismatch, expected %0h, got %0h",
                         stamp, field, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result transaction with the oldest expectation
        function void check_result(rsp_item_t got, realtime stamp);
            rsp_item_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0.1f ns: unexpected result, expected none, got kind %0d handle %0h",
                         stamp, got.kind, got.issued_handle);
                $display("    point %0d last %0d", got.bump_point, got.last);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field(stamp, "kind", want.kind, got.kind);
            compare_field(stamp, "issued_handle", want.issued_handle, got.issued_handle);
            compare_field(stamp, "bump_point", want.bump_point, got.bump_point);
            compare_field(stamp, "last", want.last, got.last);
        endfunction
    endclass

endpackage

>>> verif/tb_top.sv
// testbench top for the sync-point increment queue: clock, reset, traffic and final report
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import iosiq_pkg::*;
    import iosiq_tb_pkg::*;

    localparam int QDEPTH       = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 310;
    localparam int CALM_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 2000000;

    // selector value the block ignores
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef enum {TRAFFIC_MIX, TRAFFIC_FILL, TRAFFIC_DRAIN} traffic_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    increment_tracker_t #(QDEPTH) tracker;
    bit       calm;
    traffic_t traffic;
    int       fill_rejects;
    int       mix_left;
    int       sent_count;
    int       cycle_count;

    in_order_syncpoint_increment_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // note accepted transactions on both channels
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_result(rsp, $realtime);
        if (rst_n && cmd_valid && !cmd_stall)
            tracker.apply_request(cmd);
    end

    // result side back-pressure in bursts, none once the run calms down
    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        while (!calm)
        begin
            @(negedge clk);
            if ($urandom_range(0, 2) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles, %0d results still awaited",
                 cycle_count, tracker.awaited_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // present one request and hold it until taken, returns on the next falling edge
    task automatic send_request(input cmd_item_t c);
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (c.func != FUNC_UNUSED)
            sent_count++;
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [FUNC_W-1:0] f, input logic [POINT_W-1:0] p,
                               input logic [HANDLE_W-1:0] h);
        cmd_item_t c;
        c.func = f;
        c.sync_point = p;
        c.done_handle = h;
        send_request(c);
    endtask

    function automatic logic [POINT_W-1:0] random_point();
        if ($urandom_range(0, 4) == 0)
            return POINT_W'($urandom_range(192, 255));
        return POINT_W'($urandom_range(0, 191));
    endfunction

    // handles that mostly match nothing: zero, all ones, stale or arbitrary
    function automatic logic [HANDLE_W-1:0] stray_handle();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return HANDLE_W'($urandom_range(0, tracker.handle_ctr));
            default: return HANDLE_W'($urandom());
        endcase
    endfunction

    // mixed traffic, then fill the ring to overflow and complete it in random order, then mix again
    task automatic pick_request(output cmd_item_t c);
        logic [HANDLE_W-1:0] h;
        int                  roll;
        c.func = FUNC_IMM;
        c.sync_point = random_point();
        c.done_handle = $urandom();
        if (traffic == TRAFFIC_MIX && mix_left <= 0)
        begin
            traffic = TRAFFIC_FILL;
            fill_rejects = 0;
        end
        if (traffic == TRAFFIC_FILL && fill_rejects >= 3)
            traffic = TRAFFIC_DRAIN;
        if (traffic == TRAFFIC_DRAIN && !tracker.pick_pending(0, h))
        begin
            traffic = TRAFFIC_MIX;
            mix_left = $urandom_range(10, 40);
        end
        case (traffic)
            TRAFFIC_FILL:
            begin
                if (tracker.count >= QDEPTH)
                    fill_rejects++;
                c.func = ($urandom_range(0, 5) == 0) ? FUNC_IMM : FUNC_DEFER;
            end
            TRAFFIC_DRAIN:
            begin
                c.func = FUNC_DONE;
                if ($urandom_range(0, 7) == 0)
                    c.done_handle = stray_handle();
                else if (tracker.pick_pending($urandom_range(0, 2), h))
                    c.done_handle = h;
            end
            default:
            begin
                mix_left--;
                roll = $urandom_range(0, 19);
                if (roll < 6)
                    c.func = FUNC_IMM;
                else if (roll < 12)
                    c.func = FUNC_DEFER;
                else if (roll < 18)
                begin
                    c.func = FUNC_DONE;
                    if (tracker.pick_pending(2, h))
                        c.done_handle = h;
                end
                else if (roll == 18)
                begin
                    c.func = FUNC_DONE;
                    c.done_handle = stray_handle();
                end
                else
                    c.func = FUNC_UNUSED;
            end
        endcase
    endtask

    initial
    begin
        cmd_item_t c;
        int        target;
        tracker = new();
        calm = 1'b0;
        traffic = TRAFFIC_MIX;
        mix_left = 20;
        fill_rejects = 0;
        sent_count = 0;
        cmd_valid = 1'b0;
        cmd = '0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // done on an empty ring, immediates at the point extremes
        send_fields(FUNC_DONE, 8'h00, 32'h0000_0000);
        send_fields(FUNC_IMM, 8'h00, 32'h0000_0000);
        send_fields(FUNC_IMM, 8'hFF, 32'hFFFF_FFFF);
        // immediate queued behind a pending entry, released together
        send_fields(FUNC_DEFER, 8'd191, 32'h0000_0000);
        send_fields(FUNC_IMM, 8'd7, 32'h0000_0000);
        send_fields(FUNC_DONE, 8'h00, 32'd0);
        // handle zero hits the immediate entry first and marks nothing new
        send_fields(FUNC_DEFER, 8'd10, 32'h0000_0000);
        send_fields(FUNC_IMM, 8'd20, 32'h0000_0000);
        send_fields(FUNC_DONE, 8'h00, 32'd0);
        send_fields(FUNC_DONE, 8'h00, 32'd1);
        // out of order completion, repeated done, then the head releases all
        send_fields(FUNC_DEFER, 8'd100, 32'h0000_0000);
        send_fields(FUNC_DEFER, 8'd101, 32'h0000_0000);
        send_fields(FUNC_DEFER, 8'd102, 32'h0000_0000);
        send_fields(FUNC_DONE, 8'hFF, 32'd3);
        send_fields(FUNC_DONE, 8'h00, 32'd4);
        send_fields(FUNC_DONE, 8'h00, 32'd3);
        send_fields(FUNC_DONE, 8'h00, 32'd2);
        // no match, ignored selector, point 192 from the upper band
        send_fields(FUNC_DONE, 8'h00, 32'd2);
        send_fields(FUNC_DONE, 8'h5A, 32'hFFFF_FFFF);
        send_fields(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_fields(FUNC_IMM, 8'd192, 32'hFFFF_FFFF);

        // random traffic with request side gaps
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target)
        begin
            pick_request(c);
            send_request(c);
            if (sent_count >= target - CALM_ITEMS)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
        end
        cmd_valid <= 1'b0;

        // let the last results out and give stray ones time to show
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.awaited_results.size() != 0)
        begin
            $display("%0d results never arrived", tracker.awaited_results.size());
            tracker.errors++;
        end
        $display("%0d requests: %0d handles issued, %0d full rejections, %0d increments retired",
                 sent_count, tracker.handles_issued, tracker.rejects, tracker.bumps);
        $display("longest in-order release %0d entries on a ring of %0d, %0d mismatches",
                 tracker.max_batch, QDEPTH, tracker.errors);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/iosiq_pkg.sv
hw/rtl/iosiq_dp.sv
hw/rtl/iosiq_ctrl.sv
hw/rtl/in_order_syncpoint_increment_queue.sv
verif/iosiq_tb_pkg.sv
verif/tb_top.sv
